[src/kfphc_pkg.sv]
// ----------------------------------------------------------------------------
// kfphc_pkg: shared types and constants for the key frame hold counter
// Character codes, payload words and the control bundle sent to the key cells.
// ----------------------------------------------------------------------------
package kfphc_pkg;

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharOne     = 8'h31;

  localparam int unsigned CharW  = 8;
  localparam int unsigned QueryW = 6;
  localparam int unsigned HoldW  = 32;

  typedef struct packed {
    logic [CharW-1:0]  char_in;
    logic [QueryW-1:0] query_index;
  } kfphc_in_t;

  typedef struct packed {
    logic [HoldW-1:0] hold_frames;
    logic             frame_committed;
  } kfphc_out_t;

  // Broadcast to every cell for one accepted word
  typedef struct packed {
    logic key_we;   // a '0' or '1' arrived while the frame is not full
    logic key_val;  // pressed
    logic restart;  // newline: return the write token to the first cell
    logic commit;   // newline that closes a full frame
  } kfphc_ctrl_t;

endpackage

[src/key_frame_parser_hold_counter.sv]
// ----------------------------------------------------------------------------
// key_frame_parser_hold_counter: key frame parser with per-key hold counters
// Stores '0'/'1' characters into consecutive key slots and, on a newline that
// closes a full frame, advances or clears every key's hold counter.
// ----------------------------------------------------------------------------
// Takes one character word per clock while in_stall_o is low, with no gaps
// needed between words. Each accepted word yields exactly one registered result
// word: the queried key's hold count after that character has been applied, plus
// a flag that is set when the character was a newline ending a complete frame.
// The key slots are a row of NUM_KEYS cells; a write token walks along the row
// as key characters arrive and all counters update together on a committing
// newline. A two-entry output stage lets input keep flowing while the consumer
// holds off; in_stall_o rises only once both entries are occupied.
module key_frame_parser_hold_counter #(
  parameter int unsigned NUM_KEYS    = 32,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  kfphc_pkg::kfphc_in_t    in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output kfphc_pkg::kfphc_out_t   out_data_o
);
  import kfphc_pkg::*;

  logic                   in_accept;
  logic                   is_key, is_newline;
  kfphc_ctrl_t            ctrl;
  logic [NUM_KEYS-1:0]    tok_chain;
  logic [COUNT_WIDTH-1:0] count_d [NUM_KEYS];
  logic [COUNT_WIDTH-1:0] query_count;
  logic                   full_q, full_d;
  kfphc_out_t             result;

  kfphc_out_t out_q, out_d, skid_q, skid_d;
  logic       out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic       out_take;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;

  assign is_newline = (in_data_i.char_in == CharNewline);
  assign is_key     = (in_data_i.char_in == CharZero) || (in_data_i.char_in == CharOne);

  always_comb begin
    ctrl.key_we  = in_accept && is_key && !full_q;
    ctrl.key_val = (in_data_i.char_in == CharOne);
    ctrl.restart = in_accept && is_newline;
    ctrl.commit  = in_accept && is_newline && full_q;
  end

  // Frame is full once the token has left the last cell
  always_comb begin
    full_d = full_q;
    if (ctrl.restart) begin
      full_d = 1'b0;
    end else if (ctrl.key_we && tok_chain[NUM_KEYS-1]) begin
      full_d = 1'b1;
    end
  end

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_cell
    kfphc_cell #(
      .IS_FIRST    (i == 0),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .tok_i     ((i == 0) ? 1'b0 : tok_chain[(i == 0) ? 0 : i-1]),
      .tok_o     (tok_chain[i]),
      .count_d_o (count_d[i])
    );
  end

  // Select the queried key's updated count; out-of-range queries read zero
  always_comb begin
    query_count = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (in_data_i.query_index == QueryW'(i)) begin
        query_count = count_d[i];
      end
    end
  end

  always_comb begin
    result.hold_frames     = HoldW'(query_count);
    result.frame_committed = ctrl.commit;
  end

  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (in_accept) begin
        out_d       = result;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_accept) begin
      // hold the new word while the output stays stalled
      skid_d       = result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      full_q       <= full_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_token_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_chain))
    else $error("more than one cell holds the write token");

  a_full_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (tok_chain == '0))
    else $error("frame full while a cell still holds the write token");

  a_newline_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.restart |=> (tok_chain[0] && !full_q))
    else $error("newline did not return the token to the first cell");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry occupied while the output register is empty");
`endif

endmodule

[src/kfphc_cell.sv]
// ----------------------------------------------------------------------------
// kfphc_cell: one key slot of the frame parser
// Holds a key state, its hold counter and the write token, which moves on to
// the next cell each time a key character is stored.
// ----------------------------------------------------------------------------
module kfphc_cell #(
  parameter bit          IS_FIRST    = 1'b0,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kfphc_pkg::kfphc_ctrl_t   ctrl_i,
  input  logic                     tok_i,
  output logic                     tok_o,
  output logic [COUNT_WIDTH-1:0]   count_d_o
);
  import kfphc_pkg::*;

  logic                   tok_q, tok_d;
  logic                   key_q, key_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;

  always_comb begin
    tok_d = tok_q;
    key_d = key_q;
    count_d = count_q;
    if (ctrl_i.restart) begin
      tok_d = IS_FIRST;
    end else if (ctrl_i.key_we) begin
      tok_d = tok_i;
    end
    if (ctrl_i.key_we && tok_q) begin
      key_d = ctrl_i.key_val;
    end
    if (ctrl_i.commit) begin
      if (!key_q) begin
        count_d = '0;
      end else if (!(&count_q)) begin
        count_d = count_q + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= IS_FIRST;
      key_q   <= 1'b0;
      count_q <= '0;
    end else begin
      tok_q   <= tok_d;
      key_q   <= key_d;
      count_q <= count_d;
    end
  end

  assign tok_o     = tok_q;
  assign count_d_o = count_d;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for key_frame_parser_hold_counter
// Streams key frames (full, short, overfull, noisy) with random queries and
// checks every result word against an in-bench model of the hold counters.
// ----------------------------------------------------------------------------
module tb;
  import kfphc_pkg::*;

  localparam int unsigned NumKeys    = 32;
  localparam int unsigned TargetKeys = 1950;
  localparam int unsigned QuietTail  = 300;
  localparam int unsigned CycleLimit = 500000;

  // Model of the key row and hold counters; holds expected result words
  class key_hold_scoreboard;
    bit               key_pressed [NumKeys];
    bit [HoldW-1:0]   hold_counts [NumKeys];
    int unsigned      wr_pos;
    kfphc_out_t       expected_words [$];
    int unsigned      errors;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_char(kfphc_in_t w);
      kfphc_out_t exp_w;
      exp_w = '0;
      if (w.char_in == CharNewline) begin
        if (wr_pos >= NumKeys) begin
          foreach (hold_counts[k]) begin
            if (!key_pressed[k]) begin
              hold_counts[k] = '0;
            end else if (hold_counts[k] != {HoldW{1'b1}}) begin
              hold_counts[k] = hold_counts[k] + 1'b1;
            end
          end
          exp_w.frame_committed = 1'b1;
        end
        wr_pos = 0;
      end else if (w.char_in == CharZero || w.char_in == CharOne) begin
        // drop key characters once the frame is full
        if (wr_pos < NumKeys) begin
          key_pressed[wr_pos] = (w.char_in == CharOne);
          wr_pos++;
        end
      end
      if (w.query_index < NumKeys) begin
        exp_w.hold_frames = hold_counts[w.query_index];
      end
      expected_words.push_back(exp_w);
    endfunction

    task check_word(kfphc_out_t got);
      kfphc_out_t exp_w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.hold_frames !== exp_w.hold_frames) begin
        report($sformatf("hold_frames got %0d expected %0d",
                         got.hold_frames, exp_w.hold_frames));
      end
      if (got.frame_committed !== exp_w.frame_committed) begin
        report($sformatf("frame_committed got %b expected %b",
                         got.frame_committed, exp_w.frame_committed));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  kfphc_in_t  in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  kfphc_out_t out_data_o;

  key_hold_scoreboard sb = new();

  bit          quiet;
  int unsigned in_gap_pct;
  int unsigned stall_pct;
  int unsigned keys_sent;
  int unsigned cycle_count;

  key_frame_parser_hold_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Outputs settle after the rising edge, so sample them mid-cycle
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(out_data_o);
    end
  end

  initial begin
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CharNewline || c == CharZero || c == CharOne);
    return c;
  endfunction

  task automatic send_word(input logic [7:0] ch);
    kfphc_in_t w;
    bit        took;
    w.char_in     = ch;
    w.query_index = ($urandom_range(0, 99) < 85) ? QueryW'($urandom_range(0, NumKeys - 1))
                                                 : QueryW'($urandom_range(NumKeys, 63));
    if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    // stall is stable between edges; decide acceptance mid-cycle
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      if (took) sb.note_char(w);
      @(posedge clk_i);
    end while (!took);
    if (ch == CharNewline || ch == CharZero || ch == CharOne) keys_sent++;
  endtask

  task automatic send_frame(input logic [NumKeys-1:0] pressed, input int unsigned n_keys,
                            input int unsigned noise_pct);
    for (int unsigned k = 0; k < n_keys; k++) begin
      if ($urandom_range(0, 99) < noise_pct) send_word(noise_char());
      send_word((k < NumKeys && pressed[k]) || (k >= NumKeys && $urandom_range(0, 1))
                ? CharOne : CharZero);
    end
    send_word(CharNewline);
  endtask

  initial begin
    logic [NumKeys-1:0] held_mask;
    int unsigned        pick;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    quiet       = 1'b0;
    in_gap_pct  = 10;
    stall_pct   = 10;
    keys_sent   = 0;
    cycle_count = 0;
    held_mask   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte extremes, empty and short frames, bytes next to the key codes
    send_word(8'h00);
    send_word(8'hFF);
    send_word(CharNewline);
    send_word(CharOne);
    send_word(CharZero);
    send_word(CharNewline);
    send_word(8'h2F);
    send_word(8'h32);
    send_word(8'h09);
    send_word(8'h0B);
    send_word(8'h80);
    send_word(8'h7F);

    while (keys_sent < TargetKeys) begin
      if (keys_sent % 150 < 35) begin
        in_gap_pct = $urandom_range(0, 2) * 15;
        stall_pct  = $urandom_range(0, 2) * 10;
      end
      quiet = (keys_sent + QuietTail >= TargetKeys);
      // flip a few keys per frame so counts run up over many frames
      held_mask ^= NumKeys'($urandom & $urandom & $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(held_mask, NumKeys, ($urandom_range(0, 3) == 0) ? 10 : 0);
      end else if (pick < 72) begin
        send_frame(held_mask, NumKeys + $urandom_range(1, 6), 0);
      end else if (pick < 86) begin
        send_frame(held_mask, $urandom_range(0, NumKeys - 1), 5);
      end else if (pick < 94) begin
        send_frame($urandom_range(0, 1) ? '1 : '0, NumKeys, 0);
      end else begin
        repeat ($urandom_range(1, 8)) send_word(8'($urandom_range(0, 255)));
      end
    end

    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.expected_words.size() != 0) begin
      sb.report("expected result words left over");
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/kfphc_pkg.sv
src/kfphc_cell.sv
src/key_frame_parser_hold_counter.sv
tb/sv/tb.sv
